### src/bis_pkg.sv
package bis_pkg;

	// Default sizes of the source store and of the position fraction.
	localparam int DEF_MAX_WIDTH     = 256;
	localparam int DEF_MAX_HEIGHT    = 256;
	localparam int DEF_FRACTION_BITS = 8;

	// Field and port widths.
	localparam int CHAN_W      = 8;
	localparam int PIX_W       = 3 * CHAN_W;
	localparam int COORD_W     = 12;
	localparam int IN_SIZE_W   = 9;
	localparam int OUT_SIZE_W  = 13;
	localparam int IN_DATA_W   = 64;
	localparam int OUT_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_IN_WIDTH   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IN_HEIGHT  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUT_WIDTH  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUT_HEIGHT = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [IN_SIZE_W-1:0]  RST_IN_WIDTH   = 9'd256;
	localparam logic [IN_SIZE_W-1:0]  RST_IN_HEIGHT  = 9'd256;
	localparam logic [OUT_SIZE_W-1:0] RST_OUT_WIDTH  = 13'd512;
	localparam logic [OUT_SIZE_W-1:0] RST_OUT_HEIGHT = 13'd2048;

	// Request kinds carried on the input tuser.
	localparam logic ACT_LOAD = 1'b0;

	// Channel constants.
	localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'd255;
	localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

endpackage

### src/bis_ram.sv
module bis_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port: write when enabled, read data registered every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

### src/bilinear_image_scaler_core.sv
// Bilinear image scaler core.
// The slave stream carries requests. tuser = 0 is a load: it writes one RGB pixel
// at (src_x, src_y) into the source store and gives no result. tuser = 1 is a
// compute: it asks for the output pixel (out_row, out_col) of the scaled image
// and gives exactly one result on the master stream (R, G, B, alpha in tdata,
// out-of-range flag in tuser). Sizes are set on the cfg port while idle.
// Each request is worked on alone; s_tready is high only between requests.
// A load passes through the write state; an out-of-range compute goes straight
// to the done state. For an in-range compute, one shared restoring divider makes
// one quotient bit per cycle for the row position and then for the column
// position, and the single-port store then gives the four neighbours in turn.
// The output register holds a result until m_tready; a new request is accepted
// meanwhile, and a following compute waits in its last state until the register
// frees. Reset clears the control and sets the sizes to their reset values; the
// store is not cleared and holds nothing meaningful until written.
module bilinear_image_scaler_core import bis_pkg::*; #(
	parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// src_x, src_y, red, green, blue, out_row, out_col (from bit 0 up)
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// action
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_red, out_green, out_blue, out_alpha (from bit 0 up)
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// out_of_range
	output logic                   m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int AW  = (XW > YW) ? XW : YW;
	localparam int QW  = AW + FRACTION_BITS;
	localparam int CW  = $clog2(QW + 1);
	localparam int PW  = COORD_W + AW;
	localparam int ADW = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int WW  = 2 * FRACTION_BITS + 2;
	localparam int ACW = WW + CHAN_W;
	localparam int LW  = ADW + CHAN_W;
	localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WRITE = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	// Clamped source size minus one.
	function automatic logic [AW-1:0] size_m1(input logic [IN_SIZE_W-1:0] v,
		input int max_size);
		if (v == '0) begin
			return '0;
		end else if (int'(v) > max_size) begin
			return AW'(max_size - 1);
		end else begin
			return AW'(v - 1'b1);
		end
	endfunction

	// Control state.
	logic [2:0]            state_q;
	logic                  axis_q;
	logic [CW-1:0]         cnt_q;
	logic [1:0]            k_q;
	logic                  rd_s1;
	logic                  wr_ok_q;
	logic                  oor_q;
	logic                  m_tvalid_q;

	// Configuration.
	logic [IN_SIZE_W-1:0]  in_width_q;
	logic [IN_SIZE_W-1:0]  in_height_q;
	logic [OUT_SIZE_W-1:0] out_width_q;
	logic [OUT_SIZE_W-1:0] out_height_q;

	// Datapath.
	logic [COORD_W-1:0]    row_q;
	logic [COORD_W-1:0]    col_q;
	logic [ADW-1:0]        wr_addr_q;
	logic [PIX_W-1:0]      wr_pix_q;
	logic [OUT_SIZE_W-1:0] rem_q;
	logic [QW-1:0]         quo_q;
	logic [QW-1:0]         py_q;
	logic [QW-1:0]         px_q;
	logic [WW-1:0]         wt_s1;
	logic [ACW-1:0]        acc_q [3];
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;

	// Input fields.
	logic [CHAN_W-1:0]     in_src_x;
	logic [CHAN_W-1:0]     in_src_y;
	logic [PIX_W-1:0]      in_pix;
	logic [COORD_W-1:0]    in_row;
	logic [COORD_W-1:0]    in_col;
	logic                  in_oor;
	logic                  in_store;
	logic [LW-1:0]         wr_addr_full;
	logic                  s_acc;

	// Position mapping and division.
	logic [AW-1:0]         h_m1;
	logic [AW-1:0]         w_m1;
	logic [PW-1:0]         prod;
	logic [OUT_SIZE_W-1:0] div_d;
	logic [OUT_SIZE_W:0]   div_t;
	logic                  div_ge;
	logic [OUT_SIZE_W:0]   div_r;
	logic [QW-1:0]         div_q;

	// Neighbour reads and weights.
	logic [YW-1:0]         fy;
	logic [YW-1:0]         cy;
	logic [XW-1:0]         fx;
	logic [XW-1:0]         cx;
	logic [FRACTION_BITS-1:0] ry;
	logic [FRACTION_BITS-1:0] rx;
	logic [YW-1:0]         sel_y;
	logic [XW-1:0]         sel_x;
	logic [FRACTION_BITS:0] wy;
	logic [FRACTION_BITS:0] wx;
	logic [WW-1:0]         wt;
	logic [ADW-1:0]        rd_addr;
	logic                  ram_we;
	logic [ADW-1:0]        ram_addr;
	logic [PIX_W-1:0]      ram_rdata;
	logic [CHAN_W-1:0]     res [3];
	logic                  out_load;

	// Field unpacking of the request; a stored pixel keeps red in its top byte.
	assign in_src_x = s_tdata[7:0];
	assign in_src_y = s_tdata[15:8];
	assign in_pix   = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
	assign in_row   = s_tdata[51:40];
	assign in_col   = s_tdata[63:52];
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// Load address and range check.
	assign in_store = (int'(in_src_x) < MAX_WIDTH) && (int'(in_src_y) < MAX_HEIGHT);
	assign wr_addr_full = LW'(in_src_y) * LW'(MAX_WIDTH) + LW'(in_src_x);
	assign in_oor = ({1'b0, in_row} >= out_height_q) || ({1'b0, in_col} >= out_width_q);

	// Shared multiply and restoring divide step.
	assign h_m1   = size_m1(in_height_q, MAX_HEIGHT);
	assign w_m1   = size_m1(in_width_q, MAX_WIDTH);
	assign prod   = axis_q ? (PW'(col_q) * PW'(w_m1)) : (PW'(row_q) * PW'(h_m1));
	assign div_d  = axis_q ? out_width_q : out_height_q;
	assign div_t  = {rem_q, quo_q[QW-1]};
	assign div_ge = (div_t >= {1'b0, div_d});
	assign div_r  = div_ge ? (div_t - {1'b0, div_d}) : div_t;
	assign div_q  = {quo_q[QW-2:0], div_ge};

	// Floor and ceiling neighbours; the ceiling equals the floor when the
	// fraction is zero.
	assign fy = py_q[FRACTION_BITS +: YW];
	assign fx = px_q[FRACTION_BITS +: XW];
	assign ry = py_q[FRACTION_BITS-1:0];
	assign rx = px_q[FRACTION_BITS-1:0];
	assign cy = fy + YW'(ry != '0);
	assign cx = fx + XW'(rx != '0);

	// Neighbour k: bit 0 picks the ceiling row, bit 1 the ceiling column.
	assign sel_y   = k_q[0] ? cy : fy;
	assign sel_x   = k_q[1] ? cx : fx;
	assign rd_addr = ADW'(sel_y) * ADW'(MAX_WIDTH) + ADW'(sel_x);
	assign wy      = k_q[0] ? {1'b0, ry} : (FRAC_ONE - {1'b0, ry});
	assign wx      = k_q[1] ? {1'b0, rx} : (FRAC_ONE - {1'b0, rx});
	assign wt      = WW'(wy) * WW'(wx);

	// Store port: writes in the write state, neighbour reads otherwise.
	assign ram_we   = (state_q == ST_WRITE) && wr_ok_q;
	assign ram_addr = (state_q == ST_WRITE) ? wr_addr_q : rd_addr;

	bis_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH * MAX_HEIGHT)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wr_pix_q),
		.rdata(ram_rdata)
	);

	// Drop the fraction bits of the sums and saturate.
	always_comb begin
		logic [ACW-1:0] sh;
		for (int c = 0; c < 3; c++) begin
			sh = acc_q[c] >> (2 * FRACTION_BITS);
			res[c] = (sh > ACW'(CHAN_MAX)) ? CHAN_MAX : sh[CHAN_W-1:0];
		end
	end

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= RST_IN_WIDTH;
			in_height_q  <= RST_IN_HEIGHT;
			out_width_q  <= RST_OUT_WIDTH;
			out_height_q <= RST_OUT_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IN_WIDTH:   in_width_q   <= cfg_data[IN_SIZE_W-1:0];
				CFG_IN_HEIGHT:  in_height_q  <= cfg_data[IN_SIZE_W-1:0];
				CFG_OUT_WIDTH:  out_width_q  <= cfg_data[OUT_SIZE_W-1:0];
				CFG_OUT_HEIGHT: out_height_q <= cfg_data[OUT_SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			axis_q     <= 1'b0;
			cnt_q      <= '0;
			k_q        <= '0;
			rd_s1      <= 1'b0;
			wr_ok_q    <= 1'b0;
			oor_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_READ);
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == ACT_LOAD) begin
							wr_ok_q <= in_store;
							state_q <= ST_WRITE;
						end else if (in_oor) begin
							oor_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							oor_q   <= 1'b0;
							axis_q  <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_MUL: begin
					cnt_q   <= CW'(QW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						if (!axis_q) begin
							axis_q  <= 1'b1;
							state_q <= ST_MUL;
						end else begin
							k_q     <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			row_q     <= in_row;
			col_q     <= in_col;
			wr_addr_q <= wr_addr_full[ADW-1:0];
			wr_pix_q  <= in_pix;
		end
		if (state_q == ST_MUL) begin
			// The quotient stays below 2^QW, so the bits above QW start as
			// the partial remainder, already below the divisor.
			rem_q <= OUT_SIZE_W'(prod[PW-1:AW]);
			quo_q <= {prod[AW-1:0], {FRACTION_BITS{1'b0}}};
		end
		if (state_q == ST_DIV) begin
			rem_q <= div_r[OUT_SIZE_W-1:0];
			quo_q <= div_q;
			if (cnt_q == CW'(1)) begin
				if (!axis_q) begin
					py_q <= div_q;
				end else begin
					px_q <= div_q;
					for (int c = 0; c < 3; c++) begin
						acc_q[c] <= '0;
					end
				end
			end
		end
		wt_s1 <= wt;
		// One neighbour per cycle into the three channel sums.
		if (rd_s1) begin
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= acc_q[c] + ACW'(wt_s1) * ACW'(ram_rdata[PIX_W-CHAN_W*(c+1) +: CHAN_W]);
			end
		end
		if (out_load) begin
			m_tdata_q <= oor_q ? '0 : {FULL_ALPHA, res[2], res[1], res[0]};
			m_tuser_q <= oor_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### src/bis_checker.sv
module bis_checker import bis_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser
);

	// An out-of-range result carries all-zero channels and alpha.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("out-of-range result with nonzero data");

	// An in-range result carries full alpha.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:24] == FULL_ALPHA)
		else $error("in-range result without full alpha");

	// Every accepted request makes the block busy in the following cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted in back-to-back cycles");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind bilinear_image_scaler_core bis_checker u_bis_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
